@@ rtl/hvl_pkg.sv @@
// hvl_pkg: shared types, constants and helpers for the header value locator.
// No dependencies; every rtl file imports it.
`default_nettype none
package hvl_pkg;

   localparam int DEFAULT_MAX_NAME_BYTES   = 16;
   localparam int DEFAULT_MAX_BUFFER_BYTES = 65536;

   localparam int NAME_BYTES_W = 128;
   localparam int NAME_LEN_W   = 5;
   localparam int NAME_IDX_W   = 4;
   localparam int FIELD_W      = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LEN  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } in_word_type;

   typedef struct packed {
      logic [NAME_BYTES_W-1:0] name_bytes;
      logic [NAME_LEN_W-1:0]   name_length;
   } cfg_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] value_offset;
      logic [FIELD_W-1:0] value_length;
   } result_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/hvl_csr.sv @@
// hvl_csr: configuration registers (name bytes and name length).
// Depends on hvl_pkg.
`default_nettype none
module hvl_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hvl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hvl_pkg::CSR_DATA_W-1:0]  csr_data,
   output hvl_pkg::cfg_type                    cfg
);
   import hvl_pkg::*;

   logic [CSR_DATA_W-1:0] name_low_ff,  name_low_in;
   logic [CSR_DATA_W-1:0] name_high_ff, name_high_in;
   logic [NAME_LEN_W-1:0] name_len_ff,  name_len_in;
   logic                  wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      name_low_in  = name_low_ff;
      name_high_in = name_high_ff;
      name_len_in  = name_len_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_NAME_LOW:  name_low_in  = csr_data;
            CSR_NAME_HIGH: name_high_in = csr_data;
            CSR_NAME_LEN:  name_len_in  = csr_data[NAME_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff  <= '0;
         name_high_ff <= '0;
         name_len_ff  <= NAME_LEN_W'(1);
      end else begin
         name_low_ff  <= name_low_in;
         name_high_ff <= name_high_in;
         name_len_ff  <= name_len_in;
      end
   end

   assign cfg.name_bytes  = {name_high_ff, name_low_ff};
   assign cfg.name_length = name_len_ff;

endmodule
`default_nettype wire

@@ rtl/hvl_in_stage.sv @@
// hvl_in_stage: input register for one byte word; lets non-final bytes through
// while a result waits. Depends on hvl_pkg.
`default_nettype none
module hvl_in_stage (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         out_free,
   output hvl_pkg::in_word_type in_word,
   output logic              take
);
   import hvl_pkg::*;

   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic [7:0] data_ff, data_in;
   logic       acc;

   assign take       = valid_ff && (!last_ff || out_free);
   assign req_tready = !valid_ff || take;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      if (acc) begin
         valid_in = 1'b1;
         last_in  = req_tlast;
         data_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign in_word.valid = valid_ff;
   assign in_word.last  = last_ff;
   assign in_word.data  = data_ff;

endmodule
`default_nettype wire

@@ rtl/hvl_scan.sv @@
// hvl_scan: per-byte line and name matching state, value offset/length tracking.
// Depends on hvl_pkg.
`default_nettype none
module hvl_scan #(
   parameter int MAX_NAME_BYTES   = hvl_pkg::DEFAULT_MAX_NAME_BYTES,
   parameter int MAX_BUFFER_BYTES = hvl_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hvl_pkg::in_word_type in_word,
   input  wire logic                 take,
   input  wire hvl_pkg::cfg_type     cfg,
   output hvl_pkg::result_type       result
);
   import hvl_pkg::*;

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int CI_W  = $clog2(MAX_NAME_BYTES + 1);

   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_COMPARE = 6'b000010,
      PH_SKIP    = 6'b000100,
      PH_COLON   = 6'b001000,
      PH_VALUE   = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              cr_ff, cr_in;
   logic [CI_W-1:0]   ci_ff, ci_in;
   logic [POS_W-1:0]  mo_ff, mo_in;
   logic [POS_W-1:0]  ml_ff, ml_in;

   logic                  active;
   logic                  line_end;
   logic                  found;
   logic [NAME_LEN_W-1:0] n_eff;
   logic [NAME_LEN_W-1:0] ci_ext;
   logic [NAME_IDX_W-1:0] name_idx;
   logic [7:0]            name_chr;
   logic [7:0]            b;

   assign b        = in_word.data;
   assign active   = take && (pos_ff < POS_W'(MAX_BUFFER_BYTES));
   assign line_end = cr_ff && (b == CH_LF);
   assign n_eff    = (cfg.name_length > NAME_LEN_W'(MAX_NAME_BYTES))
                     ? NAME_LEN_W'(MAX_NAME_BYTES) : cfg.name_length;
   assign ci_ext   = NAME_LEN_W'(ci_ff);
   assign name_idx = NAME_IDX_W'(ci_ff);
   assign name_chr = cfg.name_bytes[8*name_idx +: 8];

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      mo_in    = mo_ff;
      ml_in    = ml_ff;
      if (active) begin
         unique case (phase_ff)
            PH_FIRST, PH_SKIP: begin
               if (line_end) begin
                  phase_in = PH_COMPARE;
                  ci_in    = '0;
               end
            end
            PH_COMPARE: begin
               if (line_end) begin
                  ci_in = '0;
               end else if (ci_ext < n_eff) begin
                  if (fold_case(b) == fold_case(name_chr)) begin
                     ci_in = CI_W'(ci_ff + 1'b1);
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (b == CH_COLON) begin
                  phase_in = PH_COLON;
                  mo_in    = POS_W'(pos_ff + 1'b1);
                  ml_in    = '0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_COLON: begin
               phase_in = PH_VALUE;
               ml_in    = POS_W'(1);
            end
            PH_VALUE: begin
               if (line_end) begin
                  ml_in    = POS_W'(ml_ff - 1'b1);   // CR was counted
                  phase_in = PH_DONE;
               end else begin
                  ml_in = POS_W'(ml_ff + 1'b1);
               end
            end
            PH_DONE: ;
            default: ;
         endcase
         cr_in  = (b == CH_CR);
         pos_in = POS_W'(pos_ff + 1'b1);
      end
   end

   assign found               = (phase_in == PH_VALUE) || (phase_in == PH_DONE);
   assign result.found        = found;
   assign result.value_offset = found ? FIELD_W'(mo_in) : '0;
   assign result.value_length = found ? FIELD_W'(ml_in) : '0;

   always_ff @(posedge clock) begin
      if (reset || (take && in_word.last)) begin
         phase_ff <= PH_FIRST;
         pos_ff   <= '0;
         cr_ff    <= 1'b0;
         ci_ff    <= '0;
         mo_ff    <= '0;
         ml_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cr_ff    <= cr_in;
         ci_ff    <= ci_in;
         mo_ff    <= mo_in;
         ml_ff    <= ml_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/hvl_out_stage.sv @@
// hvl_out_stage: result register driving the rsp_ channel.
// Depends on hvl_pkg.
`default_nettype none
module hvl_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire hvl_pkg::result_type result,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [0:0]              rsp_tuser
);
   import hvl_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.value_length, res_ff.value_offset};
   assign rsp_tuser  = res_ff.found;

endmodule
`default_nettype wire

@@ rtl/header_value_locator.sv @@
// header_value_locator: finds the first header line whose name matches a
// configured name and reports where its value sits in the byte stream.
// Depends on hvl_pkg, hvl_csr, hvl_in_stage, hvl_scan, hvl_out_stage.
//
// Usage:
//   req_ carries one header byte per word; req_tlast marks the last byte of
//   a buffer. rsp_ carries one word per buffer, issued for the tlast byte.
//   csr_ writes the name (index 0: bytes 0-7, 1: bytes 8-15) and the name
//   length (index 2); writes are always taken and belong between buffers.
//   Throughput is one byte per cycle while no final byte waits: the input
//   register feeds a single pass of compare/track logic that updates the scan
//   state for each byte taken. The last byte passes through the input register,
//   then the result register, before the result word is valid.
//   When rsp_tready is low, non-final bytes still flow through; a final
//   byte waits in the input register until the result register is free,
//   and req_tready drops meanwhile.
//   Reset clears the scan state, empties both registers, clears the name
//   and sets the name length to one.
//   Bytes beyond MAX_BUFFER_BYTES in a buffer are ignored.
`default_nettype none
module header_value_locator #(
   parameter int MAX_NAME_BYTES   = hvl_pkg::DEFAULT_MAX_NAME_BYTES,
   parameter int MAX_BUFFER_BYTES = hvl_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,   // [15:0] value_offset,
                                                             // [31:16] value_length
   output logic [0:0]                           rsp_tuser,   // [0] found
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hvl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hvl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hvl_pkg::*;

   cfg_type     cfg;
   in_word_type in_word;
   result_type  result;
   logic        take;
   logic        out_free;

   hvl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hvl_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .in_word    (in_word),
      .take       (take)
   );

   hvl_scan #(
      .MAX_NAME_BYTES   (MAX_NAME_BYTES),
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .in_word (in_word),
      .take    (take),
      .cfg     (cfg),
      .result  (result)
   );

   hvl_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && in_word.last),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("result without match carries nonzero fields");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_word.valid)
      else $error("accepted word missing from input register");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(take && in_word.last))
      else $error("result issued without a final byte");

endmodule
`default_nettype wire
